@@ rtl/pressure_temperature_compensation_defines.svh @@
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptc_pkg.sv @@
`default_nettype none

package ptc_pkg;

    typedef struct packed {
        logic        command;
        logic [19:0] raw_sample;
    } ptc_sample_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] value;
        logic               div_zero;
    } ptc_result_t;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_SHL,
        OP_ASR,
        OP_SX32,
        OP_MUL,
        OP_DIV,
        OP_FINE,
        OP_CHKZ,
        OP_END,
        OP_NOP
    } ptc_op_t;

    typedef enum logic [2:0] {
        REG_R0,
        REG_R1,
        REG_R2,
        REG_R3,
        REG_R4,
        REG_R5
    } ptc_reg_t;

    typedef enum logic [4:0] {
        SRC_R0,
        SRC_R1,
        SRC_R2,
        SRC_R3,
        SRC_R4,
        SRC_R5,
        SRC_T1,
        SRC_T2,
        SRC_T3,
        SRC_P1,
        SRC_P2,
        SRC_P3,
        SRC_P4,
        SRC_P5,
        SRC_P6,
        SRC_P7,
        SRC_P8,
        SRC_P9,
        SRC_FINE,
        SRC_RAW,
        SRC_K128000,
        SRC_K1048576,
        SRC_K3125,
        SRC_K128,
        SRC_K5,
        SRC_K2P47,
        SRC_ZERO
    } ptc_src_t;

    typedef enum logic [1:0] {
        CFG_TEMP,
        CFG_PRES_A,
        CFG_PRES_B,
        CFG_PRES_C
    } ptc_cfg_t;

    typedef struct packed {
        ptc_op_t    op;
        ptc_reg_t   dst;
        ptc_src_t   a;
        ptc_src_t   b;
        logic [5:0] sh;
    } ptc_uinstr_t;

    typedef struct packed {
        logic        load;
        logic        issue;
        ptc_uinstr_t ins;
        logic        emit;
        logic        emit_zero;
    } ptc_cmd_t;

    typedef struct packed {
        logic done;
        logic a_zero;
    } ptc_sts_t;

    localparam logic [5:0] PC_TEMP = 6'd0;
    localparam logic [5:0] PC_PRES = 6'd22;

    function automatic ptc_uinstr_t mk(input ptc_op_t op, input ptc_reg_t dst,
                                       input ptc_src_t a, input ptc_src_t b,
                                       input logic [5:0] sh);
        ptc_uinstr_t u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        u.sh  = sh;
        return u;
    endfunction

    function automatic ptc_uinstr_t ptc_rom(input logic [5:0] pc);
        ptc_uinstr_t u;
        case (pc)
            // temperature
            6'd0:  u = mk(OP_ASR,  REG_R0, SRC_RAW,   SRC_ZERO,  6'd3);
            6'd1:  u = mk(OP_SHL,  REG_R1, SRC_T1,    SRC_ZERO,  6'd1);
            6'd2:  u = mk(OP_SUB,  REG_R0, SRC_R0,    SRC_R1,    6'd0);
            6'd3:  u = mk(OP_MUL,  REG_R0, SRC_R0,    SRC_T2,    6'd0);
            6'd4:  u = mk(OP_SX32, REG_R0, SRC_R0,    SRC_ZERO,  6'd0);
            6'd5:  u = mk(OP_ASR,  REG_R0, SRC_R0,    SRC_ZERO,  6'd11);
            6'd6:  u = mk(OP_ASR,  REG_R1, SRC_RAW,   SRC_ZERO,  6'd4);
            6'd7:  u = mk(OP_SUB,  REG_R1, SRC_R1,    SRC_T1,    6'd0);
            6'd8:  u = mk(OP_MUL,  REG_R1, SRC_R1,    SRC_R1,    6'd0);
            6'd9:  u = mk(OP_SX32, REG_R1, SRC_R1,    SRC_ZERO,  6'd0);
            6'd10: u = mk(OP_ASR,  REG_R1, SRC_R1,    SRC_ZERO,  6'd12);
            6'd11: u = mk(OP_MUL,  REG_R1, SRC_R1,    SRC_T3,    6'd0);
            6'd12: u = mk(OP_SX32, REG_R1, SRC_R1,    SRC_ZERO,  6'd0);
            6'd13: u = mk(OP_ASR,  REG_R1, SRC_R1,    SRC_ZERO,  6'd14);
            6'd14: u = mk(OP_ADD,  REG_R0, SRC_R0,    SRC_R1,    6'd0);
            6'd15: u = mk(OP_SX32, REG_R0, SRC_R0,    SRC_ZERO,  6'd0);
            6'd16: u = mk(OP_FINE, REG_R0, SRC_R0,    SRC_ZERO,  6'd0);
            6'd17: u = mk(OP_MUL,  REG_R0, SRC_R0,    SRC_K5,    6'd0);
            6'd18: u = mk(OP_ADD,  REG_R0, SRC_R0,    SRC_K128,  6'd0);
            6'd19: u = mk(OP_SX32, REG_R0, SRC_R0,    SRC_ZERO,  6'd0);
            6'd20: u = mk(OP_ASR,  REG_R0, SRC_R0,    SRC_ZERO,  6'd8);
            6'd21: u = mk(OP_END,  REG_R0, SRC_R0,    SRC_ZERO,  6'd0);
            // pressure
            6'd22: u = mk(OP_SUB,  REG_R0, SRC_FINE,  SRC_K128000, 6'd0);
            6'd23: u = mk(OP_MUL,  REG_R1, SRC_R0,    SRC_R0,    6'd0);
            6'd24: u = mk(OP_MUL,  REG_R2, SRC_R1,    SRC_P6,    6'd0);
            6'd25: u = mk(OP_MUL,  REG_R3, SRC_R0,    SRC_P5,    6'd0);
            6'd26: u = mk(OP_SHL,  REG_R3, SRC_R3,    SRC_ZERO,  6'd17);
            6'd27: u = mk(OP_ADD,  REG_R2, SRC_R2,    SRC_R3,    6'd0);
            6'd28: u = mk(OP_SHL,  REG_R3, SRC_P4,    SRC_ZERO,  6'd35);
            6'd29: u = mk(OP_ADD,  REG_R2, SRC_R2,    SRC_R3,    6'd0);
            6'd30: u = mk(OP_MUL,  REG_R3, SRC_R1,    SRC_P3,    6'd0);
            6'd31: u = mk(OP_ASR,  REG_R3, SRC_R3,    SRC_ZERO,  6'd8);
            6'd32: u = mk(OP_MUL,  REG_R4, SRC_R0,    SRC_P2,    6'd0);
            6'd33: u = mk(OP_SHL,  REG_R4, SRC_R4,    SRC_ZERO,  6'd12);
            6'd34: u = mk(OP_ADD,  REG_R3, SRC_R3,    SRC_R4,    6'd0);
            6'd35: u = mk(OP_ADD,  REG_R3, SRC_K2P47, SRC_R3,    6'd0);
            6'd36: u = mk(OP_MUL,  REG_R3, SRC_R3,    SRC_P1,    6'd0);
            6'd37: u = mk(OP_ASR,  REG_R3, SRC_R3,    SRC_ZERO,  6'd33);
            6'd38: u = mk(OP_CHKZ, REG_R3, SRC_R3,    SRC_ZERO,  6'd0);
            6'd39: u = mk(OP_SUB,  REG_R4, SRC_K1048576, SRC_RAW, 6'd0);
            6'd40: u = mk(OP_SHL,  REG_R4, SRC_R4,    SRC_ZERO,  6'd31);
            6'd41: u = mk(OP_SUB,  REG_R4, SRC_R4,    SRC_R2,    6'd0);
            6'd42: u = mk(OP_MUL,  REG_R4, SRC_R4,    SRC_K3125, 6'd0);
            6'd43: u = mk(OP_DIV,  REG_R4, SRC_R4,    SRC_R3,    6'd0);
            6'd44: u = mk(OP_ASR,  REG_R5, SRC_R4,    SRC_ZERO,  6'd13);
            6'd45: u = mk(OP_MUL,  REG_R1, SRC_P9,    SRC_R5,    6'd0);
            6'd46: u = mk(OP_MUL,  REG_R1, SRC_R1,    SRC_R5,    6'd0);
            6'd47: u = mk(OP_ASR,  REG_R1, SRC_R1,    SRC_ZERO,  6'd25);
            6'd48: u = mk(OP_MUL,  REG_R2, SRC_P8,    SRC_R4,    6'd0);
            6'd49: u = mk(OP_ASR,  REG_R2, SRC_R2,    SRC_ZERO,  6'd19);
            6'd50: u = mk(OP_ADD,  REG_R4, SRC_R4,    SRC_R1,    6'd0);
            6'd51: u = mk(OP_ADD,  REG_R4, SRC_R4,    SRC_R2,    6'd0);
            6'd52: u = mk(OP_ASR,  REG_R4, SRC_R4,    SRC_ZERO,  6'd8);
            6'd53: u = mk(OP_SHL,  REG_R1, SRC_P7,    SRC_ZERO,  6'd4);
            6'd54: u = mk(OP_ADD,  REG_R4, SRC_R4,    SRC_R1,    6'd0);
            6'd55: u = mk(OP_END,  REG_R4, SRC_R4,    SRC_ZERO,  6'd0);
            default: u = mk(OP_NOP, REG_R0, SRC_ZERO, SRC_ZERO,  6'd0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pressure_temperature_compensation.sv @@
// Timing: from accept to result valid, set by the 64x16 multiply steps and the divide step;
// a pressure item with a zero divisor ends before the divide. The result is also held back
// while the previous result still waits at the output.
// Throughput: one item at a time; the next item is taken as soon as the previous result
// is registered, while that result still waits at the output.
// Reset: rst_n is asynchronous, active low; clears calibration, fine temperature and control.
`default_nettype none
`include "pressure_temperature_compensation_defines.svh"

module pressure_temperature_compensation (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire ptc_pkg::ptc_sample_t sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output ptc_pkg::ptc_result_t      result,
    input  wire logic                 wr_en,
    input  wire logic [1:0]           wr_index,
    input  wire logic [47:0]          wr_data
);
    import ptc_pkg::*;

    ptc_cmd_t           cmd;
    ptc_sts_t           sts;
    logic               kind;
    logic               dz;
    logic signed [31:0] val;

    ptc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .command      (sample.command),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (kind),
        .div_zero     (dz),
        .cmd          (cmd),
        .sts          (sts)
    );

    ptc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .raw_sample (sample.raw_sample),
        .cmd        (cmd),
        .sts        (sts),
        .value      (val)
    );

    assign result = '{result_kind: kind, value: val, div_zero: dz};

    `PTC_ASSERT_NEXT(a_one_item, sample_valid && !sample_stall, sample_stall, "second item taken while busy")
    `PTC_ASSERT_NOW(a_dz_value, result_valid && result.div_zero, result.result_kind && result.value == 32'sd0, "zero divisor result malformed")
    `PTC_ASSERT_NOW(a_temp_no_dz, result_valid && !result.result_kind, !result.div_zero, "temperature item flagged divide by zero")

endmodule

`default_nettype wire

@@ rtl/ptc_ctrl.sv @@
`default_nettype none

module ptc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire logic              command,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic                   result_kind,
    output logic                   div_zero,
    output ptc_pkg::ptc_cmd_t      cmd,
    input  wire ptc_pkg::ptc_sts_t sts
);
    import ptc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pc_reg, pc_next;
    logic        kind_reg, kind_next;
    logic        valid_reg, valid_next;
    logic        okind_reg, okind_next;
    logic        dz_reg, dz_next;
    logic        out_free;
    ptc_uinstr_t ins;

    always_comb
    begin
        ins          = ptc_rom(pc_reg);
        out_free     = !valid_reg || !result_stall;
        state_next   = state_reg;
        pc_next      = pc_reg;
        kind_next    = kind_reg;
        valid_next   = valid_reg && result_stall;
        okind_next   = okind_reg;
        dz_next      = dz_reg;
        sample_stall = (state_reg != ST_IDLE);
        cmd          = '0;
        cmd.ins      = ins;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    kind_next  = command;
                    pc_next    = command ? PC_PRES : PC_TEMP;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (ins.op)
                    OP_MUL, OP_DIV:
                    begin
                        cmd.issue  = 1'b1;
                        state_next = ST_WAIT;
                    end
                    OP_CHKZ:
                    begin
                        if (!sts.a_zero)
                        begin
                            pc_next = pc_reg + 6'd1;
                        end
                        else if (out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_zero = 1'b1;
                            valid_next    = 1'b1;
                            okind_next    = kind_reg;
                            dz_next       = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    OP_END:
                    begin
                        if (out_free)
                        begin
                            cmd.emit   = 1'b1;
                            valid_next = 1'b1;
                            okind_next = kind_reg;
                            dz_next    = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.issue = 1'b1;
                        pc_next   = pc_reg + 6'd1;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (sts.done)
                begin
                    pc_next    = pc_reg + 6'd1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_TEMP;
            kind_reg  <= 1'b0;
            valid_reg <= 1'b0;
            okind_reg <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            kind_reg  <= kind_next;
            valid_reg <= valid_next;
            okind_reg <= okind_next;
            dz_reg    <= dz_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_kind  = okind_reg;
    assign div_zero     = dz_reg;

endmodule

`default_nettype wire

@@ rtl/ptc_dp.sv @@
`default_nettype none

module ptc_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [1:0]        wr_index,
    input  wire logic [47:0]       wr_data,
    input  wire logic [19:0]       raw_sample,
    input  wire ptc_pkg::ptc_cmd_t cmd,
    output ptc_pkg::ptc_sts_t      sts,
    output logic signed [31:0]     value
);
    import ptc_pkg::*;

    logic [47:0] tcal_reg, pa_reg, pb_reg, pc_reg;
    logic [31:0] fine_reg, fine_next;
    logic [19:0] raw_reg;
    logic [63:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    logic [31:0] value_reg, value_next;

    logic [63:0] mul_a_reg, mul_a_next;
    logic [63:0] mul_b_reg, mul_b_next;
    logic [63:0] mul_acc_reg, mul_acc_next;
    logic [1:0]  mul_cnt_reg, mul_cnt_next;
    logic        mul_busy_reg, mul_busy_next;
    logic [79:0] mul_pp;

    logic [63:0] div_rem_reg, div_rem_next;
    logic [63:0] div_quo_reg, div_quo_next;
    logic [63:0] div_den_reg, div_den_next;
    logic        div_neg_reg, div_neg_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic        div_busy_reg, div_busy_next;
    logic [64:0] div_sh, div_diff;
    logic [63:0] div_q;

    ptc_reg_t    dst_reg, dst_next;
    logic        wr_r;
    ptc_reg_t    wr_sel;
    logic [63:0] wr_val;
    logic [63:0] op_a, op_b;
    logic        done;

    function automatic logic [63:0] sx16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] pick(input ptc_src_t s,
                                         input logic [63:0] r0, input logic [63:0] r1,
                                         input logic [63:0] r2, input logic [63:0] r3,
                                         input logic [63:0] r4, input logic [63:0] r5,
                                         input logic [47:0] tc, input logic [47:0] pa,
                                         input logic [47:0] pb, input logic [47:0] pcc,
                                         input logic [31:0] fine, input logic [19:0] raw);
        logic [63:0] v;
        case (s)
            SRC_R0:       v = r0;
            SRC_R1:       v = r1;
            SRC_R2:       v = r2;
            SRC_R3:       v = r3;
            SRC_R4:       v = r4;
            SRC_R5:       v = r5;
            SRC_T1:       v = {48'd0, tc[15:0]};
            SRC_T2:       v = sx16(tc[31:16]);
            SRC_T3:       v = sx16(tc[47:32]);
            SRC_P1:       v = {48'd0, pa[15:0]};
            SRC_P2:       v = sx16(pa[31:16]);
            SRC_P3:       v = sx16(pa[47:32]);
            SRC_P4:       v = sx16(pb[15:0]);
            SRC_P5:       v = sx16(pb[31:16]);
            SRC_P6:       v = sx16(pb[47:32]);
            SRC_P7:       v = sx16(pcc[15:0]);
            SRC_P8:       v = sx16(pcc[31:16]);
            SRC_P9:       v = sx16(pcc[47:32]);
            SRC_FINE:     v = {{32{fine[31]}}, fine};
            SRC_RAW:      v = {44'd0, raw};
            SRC_K128000:  v = 64'd128000;
            SRC_K1048576: v = 64'd1048576;
            SRC_K3125:    v = 64'd3125;
            SRC_K128:     v = 64'd128;
            SRC_K5:       v = 64'd5;
            SRC_K2P47:    v = 64'h0000_8000_0000_0000;
            default:      v = 64'd0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        op_a = pick(cmd.ins.a, r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg,
                    tcal_reg, pa_reg, pb_reg, pc_reg, fine_reg, raw_reg);
        op_b = pick(cmd.ins.b, r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg,
                    tcal_reg, pa_reg, pb_reg, pc_reg, fine_reg, raw_reg);
    end

    always_comb
    begin
        mul_pp   = mul_a_reg * mul_b_reg[15:0];
        div_sh   = {div_rem_reg, div_quo_reg[63]};
        div_diff = div_sh - {1'b0, div_den_reg};
        div_q    = {div_quo_reg[62:0], !div_diff[64]};

        wr_r          = 1'b0;
        wr_sel        = cmd.ins.dst;
        wr_val        = 64'd0;
        done          = 1'b0;
        fine_next     = fine_reg;
        value_next    = value_reg;
        dst_next      = dst_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        mul_acc_next  = mul_acc_reg;
        mul_cnt_next  = mul_cnt_reg;
        mul_busy_next = mul_busy_reg;
        div_rem_next  = div_rem_reg;
        div_quo_next  = div_quo_reg;
        div_den_next  = div_den_reg;
        div_neg_next  = div_neg_reg;
        div_cnt_next  = div_cnt_reg;
        div_busy_next = div_busy_reg;

        if (cmd.issue)
        begin
            case (cmd.ins.op)
                OP_ADD:
                begin
                    wr_r   = 1'b1;
                    wr_val = op_a + op_b;
                end
                OP_SUB:
                begin
                    wr_r   = 1'b1;
                    wr_val = op_a - op_b;
                end
                OP_SHL:
                begin
                    wr_r   = 1'b1;
                    wr_val = op_a << cmd.ins.sh;
                end
                OP_ASR:
                begin
                    wr_r   = 1'b1;
                    wr_val = $signed(op_a) >>> cmd.ins.sh;
                end
                OP_SX32:
                begin
                    wr_r   = 1'b1;
                    wr_val = {{32{op_a[31]}}, op_a[31:0]};
                end
                OP_FINE:
                begin
                    fine_next = op_a[31:0];
                end
                OP_MUL:
                begin
                    dst_next      = cmd.ins.dst;
                    mul_a_next    = op_a;
                    mul_b_next    = op_b;
                    mul_acc_next  = 64'd0;
                    mul_cnt_next  = 2'd0;
                    mul_busy_next = 1'b1;
                end
                OP_DIV:
                begin
                    dst_next      = cmd.ins.dst;
                    div_rem_next  = 64'd0;
                    div_quo_next  = op_a[63] ? (64'd0 - op_a) : op_a;
                    div_den_next  = op_b[63] ? (64'd0 - op_b) : op_b;
                    div_neg_next  = op_a[63] ^ op_b[63];
                    div_cnt_next  = 6'd0;
                    div_busy_next = 1'b1;
                end
                default:
                begin
                    wr_r = 1'b0;
                end
            endcase
        end

        if (cmd.emit)
        begin
            value_next = cmd.emit_zero ? 32'd0 : op_a[31:0];
        end

        if (mul_busy_reg)
        begin
            mul_acc_next = mul_acc_reg + mul_pp[63:0];
            mul_a_next   = mul_a_reg << 16;
            mul_b_next   = mul_b_reg >> 16;
            mul_cnt_next = mul_cnt_reg + 2'd1;
            if (mul_cnt_reg == 2'd3)
            begin
                mul_busy_next = 1'b0;
                done          = 1'b1;
                wr_r          = 1'b1;
                wr_sel        = dst_reg;
                wr_val        = mul_acc_next;
            end
        end

        if (div_busy_reg)
        begin
            div_rem_next = div_diff[64] ? div_sh[63:0] : div_diff[63:0];
            div_quo_next = div_q;
            div_cnt_next = div_cnt_reg + 6'd1;
            if (div_cnt_reg == 6'd63)
            begin
                div_busy_next = 1'b0;
                done          = 1'b1;
                wr_r          = 1'b1;
                wr_sel        = dst_reg;
                wr_val        = div_neg_reg ? (64'd0 - div_q) : div_q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg     <= '0;
            pa_reg       <= '0;
            pb_reg       <= '0;
            pc_reg       <= '0;
            fine_reg     <= '0;
            mul_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    CFG_TEMP:   tcal_reg <= wr_data;
                    CFG_PRES_A: pa_reg   <= wr_data;
                    CFG_PRES_B: pb_reg   <= wr_data;
                    CFG_PRES_C: pc_reg   <= wr_data;
                    default:    tcal_reg <= tcal_reg;
                endcase
            end
            fine_reg     <= fine_next;
            mul_busy_reg <= mul_busy_next;
            div_busy_reg <= div_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= raw_sample;
        end
        if (wr_r)
        begin
            case (wr_sel)
                REG_R0:  r0_reg <= wr_val;
                REG_R1:  r1_reg <= wr_val;
                REG_R2:  r2_reg <= wr_val;
                REG_R3:  r3_reg <= wr_val;
                REG_R4:  r4_reg <= wr_val;
                REG_R5:  r5_reg <= wr_val;
                default: r0_reg <= r0_reg;
            endcase
        end
        value_reg   <= value_next;
        dst_reg     <= dst_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_acc_reg <= mul_acc_next;
        mul_cnt_reg <= mul_cnt_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;
        div_cnt_reg <= div_cnt_next;
    end

    assign sts   = '{done: done, a_zero: (op_a == 64'd0)};
    assign value = $signed(value_reg);

endmodule

`default_nettype wire
